// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on the rising edge, reset disables
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RRL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotation residual loss check failed");

// next-cycle implication
`define RRL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rotation residual loss check failed");

`endif

// ----- src/rrl_pkg.sv -----
// ----------------------------------------------------------------------------
// rrl_pkg
// widths, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package rrl_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int DATA_W       = 16;
   localparam int PROD_W       = 2 * DATA_W;
   localparam int SUM_W        = 34;
   localparam int RES_W        = SUM_W - FRAC_BITS;
   localparam int SQ_W         = 2 * RES_W;
   localparam int BATCH_W      = 60;
   localparam int COUNT_W      = 16;
   localparam int LOSS_W       = 32;
   localparam int LOSS_SHIFT   = 2 * FRAC_BITS - 16;
   localparam int DIM          = 3;
   localparam int NUM_SUMS     = DIM * DIM;
   localparam int SEL_W        = $clog2(NUM_SUMS);
   localparam int ROW_W        = $clog2(DIM);
   localparam int DIV_CNT_W    = $clog2(BATCH_W);

   localparam logic [COUNT_W-1:0]   MAX_MATRICES = COUNT_W'(65535);
   localparam logic [ROW_W-1:0]     ROW_LAST     = ROW_W'(DIM - 1);
   localparam logic [SEL_W-1:0]     SEL_LAST     = SEL_W'(NUM_SUMS - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(BATCH_W - 1);

   // identity in the product scale: 1.0 with 2*FRAC_BITS fraction bits
   localparam logic signed [SUM_W-1:0] ONE_PROD = SUM_W'(1) << (2 * FRAC_BITS);

   typedef struct packed {
      logic             row_en;
      logic             row_last;
      logic             sq_en;
      logic [SEL_W-1:0] sq_sel;
      logic             finish;
      logic             div_load;
      logic             div_step;
      logic             emit;
   } cmd_type;

   typedef struct packed {
      logic count_full;
      logic batch_end;
      logic out_busy;
   } status_type;

endpackage

// ----- src/rotation_residual_loss_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_residual_loss_unit
// batch mean of the squared frobenius norm of I - P^T L over 3x3 matrix pairs
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  pred_a..c, label_a..c, batch_end
// rsp_      out        rsp_valid/rsp_stall  loss, matrix_total, saturated
//
// first and second row of a matrix: nine parallel multiply-accumulates
// third row: the nine residual squares go through the one shared squarer, then
//   the closing add (the squares are skipped when the count is full)
// batch end: the divider load, the one-bit-per-cycle 60-bit divide and the emit,
//   plus any wait for the output register to drain
// synchronous reset clears all sums and counters; a request is taken the next cycle
// rsp_stall holds the output register; rows are still taken while it waits, but a further batch result waits to emit
//
`include "assert_macros.svh"

module rotation_residual_loss_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_pred_a,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_pred_b,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_pred_c,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_label_a,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_label_b,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_label_c,
   input  logic                                req_batch_end,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rrl_pkg::LOSS_W-1:0]          rsp_loss,
   output logic [rrl_pkg::COUNT_W-1:0]         rsp_matrix_total,
   output logic                                rsp_saturated
);

   // command and status between sequencer and datapath
   rrl_pkg::cmd_type    cmd;
   rrl_pkg::status_type status;

   // squarer, closing add or divider at work
   logic core_busy;

   // sequencer: row counter, square sweep index, divide step count
   rrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: product sums, squarer, batch sum, divider, output register
   rrl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pred_a       (req_pred_a),
      .req_pred_b       (req_pred_b),
      .req_pred_c       (req_pred_c),
      .req_label_a      (req_label_a),
      .req_label_b      (req_label_b),
      .req_label_c      (req_label_c),
      .req_batch_end    (req_batch_end),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_loss         (rsp_loss),
      .rsp_matrix_total (rsp_matrix_total),
      .rsp_saturated    (rsp_saturated)
   );

   assign core_busy = cmd.sq_en || cmd.finish || cmd.div_step;

   // a request never lands while the squarer, closing add or divider runs
   `RRL_ASSERT_IMP(a_req_only_in_intake, clock, reset, req_valid && !req_stall, !core_busy)

   // the output register is only loaded when it is free
   `RRL_ASSERT_IMP(a_emit_into_free_slot, clock, reset, cmd.emit, !rsp_valid)

   // a result appears only right after an emit command
   `RRL_ASSERT_IMP(a_valid_after_emit, clock, reset, $rose(rsp_valid), $past(cmd.emit))

   // loading the divider is always followed by its first step
   `RRL_ASSERT_NXT(a_load_then_step, clock, reset, cmd.div_load, cmd.div_step)

endmodule

// ----- src/rrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrl_ctrl
// sequencer: row intake, residual square sweep, batch divide and emit
// ----------------------------------------------------------------------------
module rrl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rrl_pkg::status_type  status,
   output rrl_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_FINISH = 6'b000100,
      ST_LOAD   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   logic [rrl_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [rrl_pkg::SEL_W-1:0]       sel_ff, sel_in;
   logic [rrl_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      sel_in       = sel_ff;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      cmd.row_last = (row_ff == rrl_pkg::ROW_LAST);
      cmd.sq_sel   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.row_en = 1'b1;
               if (row_ff == rrl_pkg::ROW_LAST) begin
                  row_in   = '0;
                  sel_in   = '0;
                  state_in = ST_SQUARE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            if (status.count_full) begin
               state_in = ST_FINISH;
            end else begin
               cmd.sq_en = 1'b1;
               if (sel_ff == rrl_pkg::SEL_LAST) begin
                  state_in = ST_FINISH;
               end else begin
                  sel_in = sel_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = status.batch_end ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == rrl_pkg::DIV_LAST) begin
               state_in = ST_EMIT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         sel_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         sel_ff     <= sel_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// ----- src/rrl_datapath.sv -----
// ----------------------------------------------------------------------------
// rrl_datapath
// nine multiply-accumulates, shared squarer, batch sum, bit-serial divider
// ----------------------------------------------------------------------------
module rrl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rrl_pkg::cmd_type                    cmd,
   output rrl_pkg::status_type                 status,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_pred_a,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_pred_b,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_pred_c,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_label_a,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_label_b,
   input  logic signed [rrl_pkg::DATA_W-1:0]   req_label_c,
   input  logic                                req_batch_end,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [rrl_pkg::LOSS_W-1:0]          rsp_loss,
   output logic [rrl_pkg::COUNT_W-1:0]         rsp_matrix_total,
   output logic                                rsp_saturated
);

   localparam int SW = rrl_pkg::SUM_W;
   localparam int PW = rrl_pkg::PROD_W;
   localparam int RW = rrl_pkg::RES_W;
   localparam int QW = rrl_pkg::SQ_W;
   localparam int BW = rrl_pkg::BATCH_W;
   localparam int CW = rrl_pkg::COUNT_W;
   localparam int LW = rrl_pkg::LOSS_W;

   logic signed [rrl_pkg::DATA_W-1:0] pred [rrl_pkg::DIM];
   logic signed [rrl_pkg::DATA_W-1:0] lab  [rrl_pkg::DIM];
   logic signed [PW-1:0]              prod [rrl_pkg::NUM_SUMS];

   logic signed [SW-1:0] sums_ff [rrl_pkg::NUM_SUMS];
   logic signed [SW-1:0] sums_in [rrl_pkg::NUM_SUMS];

   logic signed [SW-1:0] diag_val;
   logic signed [SW-1:0] resid;
   logic signed [RW-1:0] trunc;
   logic [RW-1:0]        mag;
   logic [QW-1:0]        sq_ff;
   logic                 sq_vld_ff;
   logic [BW:0]          acc_sum;

   logic [BW-1:0] batch_ff, batch_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          batch_end_ff;

   logic [CW-1:0] rem_ff;
   logic [BW-1:0] quo_ff;
   logic [CW:0]   trial;
   logic          trial_ge;

   logic [BW-1:0] q_shift;
   logic          valid_ff;
   logic [LW-1:0] loss_ff;
   logic [CW-1:0] total_ff;
   logic          sat_ff;

   assign pred[0] = req_pred_a;
   assign pred[1] = req_pred_b;
   assign pred[2] = req_pred_c;
   assign lab[0]  = req_label_a;
   assign lab[1]  = req_label_b;
   assign lab[2]  = req_label_c;

   // outer-product lanes: sum[i*3+j] gathers p[i]*l[j]
   always_comb begin
      for (int i = 0; i < rrl_pkg::DIM; i++) begin
         for (int j = 0; j < rrl_pkg::DIM; j++) begin
            prod[i * rrl_pkg::DIM + j] = pred[i] * lab[j];
         end
      end
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
         if (cmd.finish) begin
            sums_in[k] = '0;
         end else if (cmd.row_en) begin
            sums_in[k] = sums_ff[k] + SW'(prod[k]);
         end else begin
            sums_in[k] = sums_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
            sums_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
            sums_ff[k] <= sums_in[k];
         end
      end
   end

   // diagonal entries sit at multiples of four in the row-major 3x3 layout
   assign diag_val = (cmd.sq_sel[1:0] == 2'b00) ? rrl_pkg::ONE_PROD : '0;
   assign resid    = diag_val - sums_ff[cmd.sq_sel];
   assign trunc    = RW'(resid >>> rrl_pkg::FRAC_BITS);
   assign mag      = trunc[RW-1] ? RW'(-trunc) : RW'(trunc);

   always_ff @(posedge clock) begin
      sq_ff <= mag * mag;
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= cmd.sq_en;
      end
   end

   // saturating batch sum, one square per cycle
   assign acc_sum = {1'b0, batch_ff} + (BW + 1)'(sq_ff);

   always_comb begin
      batch_in = batch_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.emit) begin
         batch_in = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (sq_vld_ff) begin
            if (acc_sum[BW]) begin
               batch_in = '1;
               ovf_in   = 1'b1;
            end else begin
               batch_in = acc_sum[BW-1:0];
            end
         end
         if (cmd.finish) begin
            if (status.count_full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         batch_ff <= batch_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_en && cmd.row_last) begin
         batch_end_ff <= req_batch_end;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[BW-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= batch_ff;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? CW'(trial - {1'b0, count_ff}) : trial[CW-1:0];
         quo_ff <= {quo_ff[BW-2:0], trial_ge};
      end
   end

   assign q_shift = quo_ff >> rrl_pkg::LOSS_SHIFT;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         total_ff <= count_ff;
         if (count_ff == '0) begin
            loss_ff <= '0;
            sat_ff  <= ovf_ff;
         end else if (|q_shift[BW-1:LW]) begin
            loss_ff <= '1;
            sat_ff  <= 1'b1;
         end else begin
            loss_ff <= q_shift[LW-1:0];
            sat_ff  <= ovf_ff;
         end
      end
   end

   assign status.count_full = (count_ff == rrl_pkg::MAX_MATRICES);
   assign status.batch_end  = batch_end_ff;
   assign status.out_busy   = valid_ff;

   assign rsp_valid        = valid_ff;
   assign rsp_loss         = loss_ff;
   assign rsp_matrix_total = total_ff;
   assign rsp_saturated    = sat_ff;

endmodule

// ----- tb/sv/rotation_residual_loss_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_residual_loss_unit_tb
// self-checking bench for the batch rotation residual loss unit: rows of
// prediction and label matrices go in, and each closing batch is checked for
// its mean squared residual norm, matrix count and saturation flag against a
// cycle-free model of the accumulate, square, sum and divide path
// ----------------------------------------------------------------------------
module rotation_residual_loss_unit_tb;

   // row end patterns: bit k is batch_end on row k of a matrix
   localparam logic [rrl_pkg::DIM-1:0] KEEP_OPEN   = 3'b000;
   localparam logic [rrl_pkg::DIM-1:0] CLOSE_BATCH = 3'b100;
   localparam logic [rrl_pkg::DIM-1:0] EARLY_ONLY  = 3'b011;

   localparam logic signed [rrl_pkg::DATA_W-1:0] WORD_MIN  = 16'sh8000;
   localparam logic signed [rrl_pkg::DATA_W-1:0] WORD_MAX  = 16'sh7FFF;
   localparam logic signed [rrl_pkg::DATA_W-1:0] UNIT_WORD = 16'sh4000;

   // 1.0 in the product scale, sum ceiling and loss ceiling
   localparam longint          UNIT_PROD  = longint'(1) << (2 * rrl_pkg::FRAC_BITS);
   localparam longint unsigned SUM_LIMIT  = (64'd1 << rrl_pkg::BATCH_W) - 1;
   localparam longint unsigned LOSS_LIMIT = (64'd1 << rrl_pkg::LOSS_W) - 1;

   typedef struct packed {
      logic [rrl_pkg::LOSS_W-1:0]  loss;
      logic [rrl_pkg::COUNT_W-1:0] total;
      logic                        sat;
   } loss_result_type;

   // clock, reset and dut ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid     = 1'b0;
   logic                              req_stall;
   logic signed [rrl_pkg::DATA_W-1:0] req_pred_a    = '0;
   logic signed [rrl_pkg::DATA_W-1:0] req_pred_b    = '0;
   logic signed [rrl_pkg::DATA_W-1:0] req_pred_c    = '0;
   logic signed [rrl_pkg::DATA_W-1:0] req_label_a   = '0;
   logic signed [rrl_pkg::DATA_W-1:0] req_label_b   = '0;
   logic signed [rrl_pkg::DATA_W-1:0] req_label_c   = '0;
   logic                              req_batch_end = 1'b0;

   logic                              rsp_valid;
   logic                              rsp_stall     = 1'b0;
   logic [rrl_pkg::LOSS_W-1:0]        rsp_loss;
   logic [rrl_pkg::COUNT_W-1:0]       rsp_matrix_total;
   logic                              rsp_saturated;

   // matrix staging: row-major, element k*DIM+j is row k column j
   logic signed [rrl_pkg::DATA_W-1:0] pred_m  [rrl_pkg::NUM_SUMS];
   logic signed [rrl_pkg::DATA_W-1:0] label_m [rrl_pkg::NUM_SUMS];

   // loss model state, mirrors what the unit holds between requests
   longint          prod_sum [rrl_pkg::NUM_SUMS];
   int              row_count     = 0;
   longint unsigned sq_total      = 0;
   int              matrix_seen   = 0;
   bit              overflow_flag = 1'b0;

   loss_result_type loss_expect_q [$];
   int              error_count = 0;

   // sender burst shaping and receiver stall pattern
   int burst_left  = 0;
   int stall_left  = 0;
   bit stall_phase = 1'b0;

   rotation_residual_loss_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pred_a       (req_pred_a),
      .req_pred_b       (req_pred_b),
      .req_pred_c       (req_pred_c),
      .req_label_a      (req_label_a),
      .req_label_b      (req_label_b),
      .req_label_c      (req_label_c),
      .req_batch_end    (req_batch_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_loss         (rsp_loss),
      .rsp_matrix_total (rsp_matrix_total),
      .rsp_saturated    (rsp_saturated)
   );

   always #5 clock = ~clock;

   // one row into the loss model; pushes the batch result when a batch closes
   function automatic void predict_row(input logic signed [rrl_pkg::DATA_W-1:0] pa, pb, pc,
                                       input logic signed [rrl_pkg::DATA_W-1:0] la, lb, lc,
                                       input logic last);
      longint          p [rrl_pkg::DIM];
      longint          l [rrl_pkg::DIM];
      longint          r;
      longint          t;
      longint unsigned norm;
      longint unsigned q;
      loss_result_type res;
      p[0] = pa;
      p[1] = pb;
      p[2] = pc;
      l[0] = la;
      l[1] = lb;
      l[2] = lc;
      // outer product of the row pair, accumulated into P^T L
      for (int i = 0; i < rrl_pkg::DIM; i++)
         for (int j = 0; j < rrl_pkg::DIM; j++)
            prod_sum[i * rrl_pkg::DIM + j] += p[i] * l[j];
      if (row_count < rrl_pkg::DIM - 1) begin
         row_count++;
         return;
      end
      // third row closes the matrix
      if (matrix_seen >= int'(rrl_pkg::MAX_MATRICES)) begin
         // count ceiling reached: matrix dropped, flag raised
         overflow_flag = 1'b1;
      end else begin
         norm = 0;
         for (int i = 0; i < rrl_pkg::DIM; i++) begin
            for (int j = 0; j < rrl_pkg::DIM; j++) begin
               r = ((i == j) ? UNIT_PROD : 64'sd0) - prod_sum[i * rrl_pkg::DIM + j];
               // arithmetic shift floors toward minus infinity
               t = r >>> rrl_pkg::FRAC_BITS;
               norm += longint'(t * t);
            end
         end
         if (norm > SUM_LIMIT - sq_total) begin
            sq_total      = SUM_LIMIT;
            overflow_flag = 1'b1;
         end else begin
            sq_total += norm;
         end
         matrix_seen++;
      end
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++)
         prod_sum[k] = 0;
      row_count = 0;
      // batch_end only counts on the closing row
      if (!last)
         return;
      q       = (matrix_seen != 0) ? sq_total / longint'(matrix_seen) : 64'd0;
      q       = q >> rrl_pkg::LOSS_SHIFT;
      res.sat = overflow_flag;
      if (q > LOSS_LIMIT) begin
         q       = LOSS_LIMIT;
         res.sat = 1'b1;
      end
      res.loss  = q[rrl_pkg::LOSS_W-1:0];
      res.total = matrix_seen[rrl_pkg::COUNT_W-1:0];
      loss_expect_q.push_back(res);
      sq_total      = 0;
      matrix_seen   = 0;
      overflow_flag = 1'b0;
   endfunction

   // full-scale words show up often, otherwise any 16-bit pattern
   function automatic logic signed [rrl_pkg::DATA_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return UNIT_WORD;
         4: return -UNIT_WORD;
         default: return rrl_pkg::DATA_W'($urandom);
      endcase
   endfunction

   // either a pair of near-rotations (small residual) or arbitrary contents
   function automatic void fill_random_matrix();
      bit near_unit;
      near_unit = ($urandom_range(0, 1) == 0);
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
         if (near_unit) begin
            pred_m[k]  = rrl_pkg::DATA_W'(
                            ((k % (rrl_pkg::DIM + 1)) == 0 ? int'(UNIT_WORD) : 0)
                            + int'($urandom_range(0, 1023)) - 512);
            label_m[k] = rrl_pkg::DATA_W'(
                            ((k % (rrl_pkg::DIM + 1)) == 0 ? int'(UNIT_WORD) : 0)
                            + int'($urandom_range(0, 1023)) - 512);
         end else begin
            pred_m[k]  = rand_word();
            label_m[k] = rand_word();
         end
      end
   endfunction

   // drives one request and holds it until taken; valid stays high afterwards
   task automatic send_row(input logic signed [rrl_pkg::DATA_W-1:0] pa, pb, pc,
                           input logic signed [rrl_pkg::DATA_W-1:0] la, lb, lc,
                           input logic last);
      int gap;
      // new burst: random length, with an optional gap in front of it
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_pred_a    <= pa;
      req_pred_b    <= pb;
      req_pred_c    <= pc;
      req_label_a   <= la;
      req_label_b   <= lb;
      req_label_c   <= lc;
      req_batch_end <= last;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_row(pa, pb, pc, la, lb, lc, last);
   endtask

   // three rows from the staging arrays
   task automatic send_matrix(input logic [rrl_pkg::DIM-1:0] end_bits);
      for (int k = 0; k < rrl_pkg::DIM; k++)
         send_row(pred_m[k * rrl_pkg::DIM], pred_m[k * rrl_pkg::DIM + 1],
                  pred_m[k * rrl_pkg::DIM + 2],
                  label_m[k * rrl_pkg::DIM], label_m[k * rrl_pkg::DIM + 1],
                  label_m[k * rrl_pkg::DIM + 2],
                  end_bits[k]);
   endtask

   // sender goes quiet until the unit has delivered everything owed
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (loss_expect_q.size() != 0)
         @(posedge clock);
   endtask

   // exact identity pair gives zero loss; zero pair leaves the identity, loss 3.0
   task automatic test_identity_and_zero();
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
         pred_m[k]  = ((k % (rrl_pkg::DIM + 1)) == 0) ? UNIT_WORD : '0;
         label_m[k] = ((k % (rrl_pkg::DIM + 1)) == 0) ? UNIT_WORD : '0;
      end
      send_matrix(CLOSE_BATCH);
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
         pred_m[k]  = '0;
         label_m[k] = '0;
      end
      send_matrix(CLOSE_BATCH);
   endtask

   // largest products of both signs, two matrices in one batch
   task automatic test_full_scale();
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
         pred_m[k]  = WORD_MIN;
         label_m[k] = WORD_MIN;
      end
      send_matrix(KEEP_OPEN);
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++) begin
         pred_m[k]  = WORD_MAX;
         label_m[k] = WORD_MIN;
      end
      send_matrix(CLOSE_BATCH);
   endtask

   // tiny residuals just off the grid, negative ones must floor to -1
   task automatic test_floor_truncation();
      pred_m  = '{3, 0, 0, 0, 1, 0, 0, 0, -1};
      label_m = '{0, 5, -7, 1, 1, 0, 0, 0, 1};
      send_matrix(CLOSE_BATCH);
   endtask

   // batch_end on the first two rows is ignored; the batch closes one matrix later
   task automatic test_early_batch_end();
      fill_random_matrix();
      send_matrix(EARLY_ONLY);
      fill_random_matrix();
      send_matrix(CLOSE_BATCH);
   endtask

   // random batches of mostly few matrices, stray batch_end on early rows
   task automatic test_random_batches(input int row_goal);
      int                      rows_sent;
      int                      batch_len;
      logic [rrl_pkg::DIM-1:0] end_bits;
      rows_sent = 0;
      while (rows_sent < row_goal) begin
         batch_len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14)
                                                  : $urandom_range(1, 4);
         for (int m = 0; m < batch_len; m++) begin
            fill_random_matrix();
            end_bits[0] = ($urandom_range(0, 3) == 0);
            end_bits[1] = ($urandom_range(0, 3) == 0);
            end_bits[2] = (m == batch_len - 1);
            send_matrix(end_bits);
            rows_sent += rrl_pkg::DIM;
         end
      end
   endtask

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // receiver: runs of stall and no stall, now and then a long hold of the output
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_phase = ($urandom_range(0, 2) == 0);
         if (stall_phase)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
         else
            stall_left = $urandom_range(1, 40);
      end
      stall_left--;
      rsp_stall <= stall_phase;
   end

   // every accepted result is matched against the oldest expected one
   always @(posedge clock) begin : result_check
      loss_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (loss_expect_q.size() == 0) begin
            $display("%0t: unexpected result loss %0h matrix_total %0d saturated %b",
                     $time, rsp_loss, rsp_matrix_total, rsp_saturated);
            error_count++;
         end else begin
            want = loss_expect_q.pop_front();
            check_field("loss", want.loss, rsp_loss);
            check_field("matrix_total", want.total, rsp_matrix_total);
            check_field("saturated", want.sat, rsp_saturated);
         end
      end
   end

   // main sequence
   initial begin
      for (int k = 0; k < rrl_pkg::NUM_SUMS; k++)
         prod_sum[k] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_identity_and_zero();
      test_full_scale();
      test_floor_truncation();
      test_early_batch_end();
      test_random_batches(650);

      // drain fully before the second random run
      wait_for_results();
      test_random_batches(650);

      // everything delivered, then room for the divider and output register
      wait_for_results();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- rotation_residual_loss_unit.f -----
+incdir+src
src/rrl_pkg.sv
src/rrl_ctrl.sv
src/rrl_datapath.sv
src/rotation_residual_loss_unit.sv
tb/sv/rotation_residual_loss_unit_tb.sv
